FILE: hdl/xcfr_pkg.sv
// Shared types and constants for the XOR-checked frame reassembler.
`default_nettype none
package xcfr_pkg;

    // Framing bytes
    localparam logic [7:0] START_BYTE = 8'h27;
    localparam logic [7:0] DIR_BYTE   = 8'h01;
    localparam logic [7:0] TAIL_BYTE  = 8'hFB;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EOF     = 1'b1;

    // End-of-frame status codes
    localparam logic [1:0] STATUS_MORE   = 2'd0;
    localparam logic [1:0] STATUS_DONE   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Operation queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Output data word width (58 field bits padded to whole bytes)
    localparam int OUT_DW = 64;

    // One classified operation from the parser
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] command;
        logic [7:0]  payload_length;
        logic [7:0]  frame_number;
        logic [7:0]  frame_total;
    } t_op;

    // Push side of the operation queue
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    // Pop side of the operation queue
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

endpackage
`default_nettype wire

FILE: hdl/xcfr_front.sv
// Frame parser: walks the byte stream and turns payload and tail bytes into operations.
`default_nettype none
module xcfr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_q_full,
    output xcfr_pkg::t_push    o_push
);
    import xcfr_pkg::*;

    typedef enum logic [3:0] {
        S_HUNT, S_DIR, S_CMDH, S_CMDL, S_LEN,
        S_PAYLOAD, S_FID, S_FCNT, S_CHECK, S_TAIL
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_fid, n_fid;
    logic [7:0]  r_fcnt, n_fcnt;
    logic        r_chk, n_chk;
    logic        w_acc;
    logic [7:0]  w_seen_inc;
    logic [1:0]  w_status;

    assign o_ready    = !i_q_full;
    assign w_acc      = i_valid && !i_q_full;
    assign w_seen_inc = r_seen + 8'd1;

    // Grade the frame at the tail byte
    always_comb begin
        if (r_chk && i_byte == TAIL_BYTE) begin
            w_status = (r_fid == r_fcnt) ? STATUS_DONE : STATUS_MORE;
        end else begin
            w_status = STATUS_REJECT;
        end
    end

    // Next parser state and frame fields
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_seen  = r_seen;
        n_xor   = r_xor;
        n_fid   = r_fid;
        n_fcnt  = r_fcnt;
        n_chk   = r_chk;
        case (r_state)
            S_HUNT: begin
                if (i_byte == START_BYTE) n_state = S_DIR;
            end
            S_DIR: begin
                if (i_byte == DIR_BYTE) begin
                    n_xor   = i_byte;
                    n_state = S_CMDH;
                end else if (i_byte != START_BYTE) begin
                    n_state = S_HUNT;
                end
            end
            S_CMDH: begin
                n_cmd   = {i_byte, r_cmd[7:0]};
                n_xor   = r_xor ^ i_byte;
                n_state = S_CMDL;
            end
            S_CMDL: begin
                n_cmd   = {r_cmd[15:8], i_byte};
                n_xor   = r_xor ^ i_byte;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_len   = i_byte;
                n_seen  = 8'd0;
                n_xor   = r_xor ^ i_byte;
                n_state = (i_byte == 8'd0) ? S_FID : S_PAYLOAD;
            end
            S_PAYLOAD: begin
                n_seen = w_seen_inc;
                n_xor  = r_xor ^ i_byte;
                if (w_seen_inc == r_len) n_state = S_FID;
            end
            S_FID: begin
                n_fid   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_state = S_FCNT;
            end
            S_FCNT: begin
                n_fcnt  = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_chk   = (i_byte == r_xor);
                n_state = S_TAIL;
            end
            S_TAIL: begin
                n_state = S_HUNT;
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // Build the operation for payload and tail bytes
    always_comb begin
        o_push.valid              = w_acc && (r_state == S_PAYLOAD || r_state == S_TAIL);
        o_push.op.command         = r_cmd;
        o_push.op.payload_length  = r_len;
        if (r_state == S_TAIL) begin
            o_push.op.kind         = KIND_EOF;
            o_push.op.data         = 8'd0;
            o_push.op.status       = w_status;
            o_push.op.frame_number = r_fid;
            o_push.op.frame_total  = r_fcnt;
        end else begin
            o_push.op.kind         = KIND_PAYLOAD;
            o_push.op.data         = i_byte;
            o_push.op.status       = STATUS_MORE;
            o_push.op.frame_number = 8'd0;
            o_push.op.frame_total  = 8'd0;
        end
    end

    // Advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_xor   <= '0;
            r_fid   <= '0;
            r_fcnt  <= '0;
            r_chk   <= 1'b0;
        end else if (w_acc) begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_xor   <= n_xor;
            r_fid   <= n_fid;
            r_fcnt  <= n_fcnt;
            r_chk   <= n_chk;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xcfr_queue.sv
// Short FIFO of parsed operations between the parser and the output stage.
`default_nettype none
module xcfr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xcfr_pkg::t_push i_push,
    output logic               o_full,
    output xcfr_pkg::t_head    o_head,
    input  wire logic          i_pop
);
    import xcfr_pkg::*;

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full       = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_mem[r_rd_ptr];
    assign w_do_push    = i_push.valid && !o_full;
    assign w_do_pop     = i_pop && o_head.valid;

    // Store pushed operations
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_push.op;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xcfr_back.sv
// Output stage: assigns reassembly offsets and holds the result register.
`default_nettype none
module xcfr_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire xcfr_pkg::t_head               i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [xcfr_pkg::OUT_DW-1:0]        o_data,
    output logic                               o_kind
);
    import xcfr_pkg::*;

    logic              r_valid;
    logic [7:0]        r_wpos, n_wpos;
    logic [OUT_DW-1:0] r_data, n_data;
    logic              r_kind;
    logic [7:0]        w_offset;

    assign o_pop    = i_head.valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_kind   = r_kind;
    assign w_offset = (i_head.op.kind == KIND_PAYLOAD) ? r_wpos : 8'd0;

    // Next write position and packed result word
    always_comb begin
        n_wpos = r_wpos;
        if (i_head.op.kind == KIND_PAYLOAD) begin
            n_wpos = r_wpos + 8'd1;
        end else if (i_head.op.status == STATUS_DONE) begin
            n_wpos = 8'd0;
        end
        n_data = {6'd0,
                  i_head.op.frame_total,
                  i_head.op.frame_number,
                  i_head.op.payload_length,
                  i_head.op.command,
                  i_head.op.status,
                  w_offset,
                  i_head.op.data};
    end

    // Load a result when the register is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wpos  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_wpos  <= n_wpos;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_kind <= i_head.op.kind;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/xor_checked_frame_reassembler.sv
// Top level of the XOR-checked frame reassembler.
//
//  channel  | dir | tdata                                              | tuser
//  ---------+-----+----------------------------------------------------+------
//  s_axis   | in  | [7:0] rx_byte                                      | -
//  m_axis   | out | [7:0] data, [15:8] offset, [17:16] status,         | kind
//           |     | [33:18] command, [41:34] payload_length,           |
//           |     | [49:42] frame_number, [57:50] frame_total, 0 pad   |
//
// One byte is taken per cycle while the queue has room; the parser registers its state
// on each accepted byte. A result is offered on m_axis once its byte is accepted, its
// operation is written into the four-entry operation queue and then loaded into the
// output register, which takes it only while that register is empty or being drained.
// Reset (synchronous, active low) returns the parser to hunting and empties the queue.
// s_axis stalls only while the queue is full, so four results wait in the queue behind
// the one held in a stalled output register before input backpressure appears.
`default_nettype none
module xor_checked_frame_reassembler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [7:0] data, [15:8] offset, [17:16] status, [33:18] command,
    // [41:34] payload_length, [49:42] frame_number, [57:50] frame_total
    output logic [xcfr_pkg::OUT_DW-1:0]        o_m_axis_tdata,
    output logic                               o_m_axis_tuser   // [0] kind
);
    import xcfr_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    // Parse incoming bytes
    xcfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_q_full (w_full),
        .o_push   (w_push)
    );

    // Buffer classified operations
    xcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Assign offsets and drive results
    xcfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_kind  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: verif/xor_checked_frame_reassembler_tb.sv
// Self-checking testbench for the XOR-checked frame reassembler: byte stream in, results checked.
`timescale 1ns / 100ps
module xor_checked_frame_reassembler_tb;
    import xcfr_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int RANDOM_BYTES = 850;
    localparam int LONG_HOLD    = 120;   // receiver hold-off, long enough to fill the queue
    localparam int DRAIN_EVERY  = 250;   // bytes between sender pauses

    // Parser position, mirrors the frame layout
    typedef enum logic [3:0] {
        P_HUNT, P_DIR, P_CMDH, P_CMDL, P_LEN, P_PAYLOAD, P_FID, P_FCNT, P_CHECK, P_TAIL
    } parse_step_e;

    // Ways a generated frame can be spoiled
    typedef enum logic [1:0] {FLAW_NONE, FLAW_CHECK, FLAW_TAIL, FLAW_CUT} frame_flaw_e;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  offset;
        logic [1:0]  status;
        logic [15:0] command;
        logic [7:0]  plen;
        logic [7:0]  fnum;
        logic [7:0]  ftot;
    } t_result;

    typedef struct {
        bit         drain;  // pause here until all results are back
        logic [7:0] rx;
    } t_link_item;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [OUT_DW-1:0] m_tdata;  // [7:0] data, [15:8] offset, [17:16] status, [33:18] command,
                                 // [41:34] payload_length, [49:42] frame_number,
                                 // [57:50] frame_total
    logic        m_tuser;   // [0] kind

    t_link_item  link_bytes[$];
    t_result     frame_results_due[$];

    // Parser mirror state
    parse_step_e pstep;
    logic [15:0] cmd_r;
    logic [7:0]  len_r;
    logic [7:0]  seen_r;
    logic [7:0]  xor_acc;
    logic [7:0]  fid_r;
    logic [7:0]  fcnt_r;
    logic        check_ok;
    logic [7:0]  wr_pos;

    // Handshake bookkeeping
    bit s_took;
    bit m_took;
    int s_gap, s_quiet;
    int r_wait, r_quiet, hold_left;
    int idle_cycles;

    int mismatches;
    int results_checked;
    int stim_bytes;
    int bytes_taken;
    int payload_results, frames_more, frames_done, frames_rejected;

    xor_checked_frame_reassembler uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Wait per item: mostly random, with occasional stretches of back-to-back items
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Advance the parser mirror by one byte and queue any result it yields
    task automatic reassemble_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        case (pstep)
            P_HUNT: if (b == START_BYTE) pstep = P_DIR;
            P_DIR: begin
                if (b == DIR_BYTE) begin
                    xor_acc = b;
                    pstep = P_CMDH;
                end else if (b != START_BYTE) begin
                    pstep = P_HUNT;
                end
            end
            P_CMDH: begin
                cmd_r[15:8] = b;
                xor_acc ^= b;
                pstep = P_CMDL;
            end
            P_CMDL: begin
                cmd_r[7:0] = b;
                xor_acc ^= b;
                pstep = P_LEN;
            end
            P_LEN: begin
                len_r = b;
                seen_r = '0;
                xor_acc ^= b;
                pstep = (b == 8'd0) ? P_FID : P_PAYLOAD;
            end
            P_PAYLOAD: begin
                r.kind = KIND_PAYLOAD;
                r.data = b;
                r.offset = wr_pos;
                r.command = cmd_r;
                r.plen = len_r;
                frame_results_due.push_back(r);
                payload_results++;
                wr_pos = wr_pos + 8'd1;
                seen_r = seen_r + 8'd1;
                xor_acc ^= b;
                if (seen_r == len_r) pstep = P_FID;
            end
            P_FID: begin
                fid_r = b;
                xor_acc ^= b;
                pstep = P_FCNT;
            end
            P_FCNT: begin
                fcnt_r = b;
                xor_acc ^= b;
                pstep = P_CHECK;
            end
            P_CHECK: begin
                check_ok = (b == xor_acc);
                pstep = P_TAIL;
            end
            P_TAIL: begin
                r.kind = KIND_EOF;
                if (check_ok && b == TAIL_BYTE) begin
                    if (fid_r == fcnt_r) begin
                        r.status = STATUS_DONE;
                        wr_pos = '0;
                        frames_done++;
                    end else begin
                        r.status = STATUS_MORE;
                        frames_more++;
                    end
                end else begin
                    r.status = STATUS_REJECT;
                    frames_rejected++;
                end
                r.command = cmd_r;
                r.plen = len_r;
                r.fnum = fid_r;
                r.ftot = fcnt_r;
                frame_results_due.push_back(r);
                pstep = P_HUNT;
            end
            default: pstep = P_HUNT;
        endcase
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_link_item it;
        it.drain = 1'b0;
        it.rx = b;
        link_bytes.push_back(it);
        stim_bytes++;
    endtask

    task automatic push_drain();
        t_link_item it;
        it.drain = 1'b1;
        it.rx = '0;
        link_bytes.push_back(it);
    endtask

    // Build one frame; a cut frame is abandoned partway through
    task automatic add_frame(input logic [15:0] cmd, input logic [7:0] len,
                             input logic [7:0] first_pl, input logic [7:0] fid,
                             input logic [7:0] fcnt, input frame_flaw_e flaw);
        logic [7:0] frame[$];
        logic [7:0] chk;
        logic [7:0] tail;
        int keep;
        frame = {START_BYTE, DIR_BYTE, cmd[15:8], cmd[7:0], len};
        for (int i = 0; i < int'(len); i++)
            frame.push_back(i == 0 ? first_pl : 8'($urandom));
        frame.push_back(fid);
        frame.push_back(fcnt);
        chk = '0;
        foreach (frame[i])
            if (i > 0) chk ^= frame[i];
        if (flaw == FLAW_CHECK) chk ^= 8'($urandom_range(1, 255));
        frame.push_back(chk);
        tail = TAIL_BYTE;
        if (flaw == FLAW_TAIL) begin
            tail = 8'($urandom);
            if (tail == TAIL_BYTE) tail = ~tail;
        end
        frame.push_back(tail);
        keep = (flaw == FLAW_CUT) ? $urandom_range(2, frame.size() - 2) : frame.size();
        for (int i = 0; i < keep; i++) push_byte(frame[i]);
    endtask

    // Sample handshakes, update the mirror and check results
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                s_took = 1'b1;
                bytes_taken++;
                reassemble_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                m_took = 1'b1;
                results_checked++;
                if (frame_results_due.size() == 0) begin
                    $display("%0t: result with none expected: expected nothing, got %0h/%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = frame_results_due.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(m_tuser));
                    compare_field("data", 16'(want.data), 16'(m_tdata[7:0]));
                    compare_field("offset", 16'(want.offset), 16'(m_tdata[15:8]));
                    compare_field("status", 16'(want.status), 16'(m_tdata[17:16]));
                    compare_field("command", want.command, m_tdata[33:18]);
                    compare_field("payload_length", 16'(want.plen), 16'(m_tdata[41:34]));
                    compare_field("frame_number", 16'(want.fnum), 16'(m_tdata[49:42]));
                    compare_field("frame_total", 16'(want.ftot), 16'(m_tdata[57:50]));
                    compare_field("pad", 16'd0, 16'(m_tdata[OUT_DW-1:58]));
                end
            end
        end
    end

    // Stop the run when neither side moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, frame_results_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Sender: offer queued bytes with random gaps, hold at pause markers
    always @(negedge clk) begin
        logic       v;
        logic [7:0] d;
        t_link_item it;
        v = s_tvalid;
        d = s_tdata;
        if (rst_n) begin
            if (s_took) begin
                s_took = 1'b0;
                v = 1'b0;
                s_gap = draw_wait(s_quiet);
            end
            if (!v) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (link_bytes.size() > 0) begin
                    if (link_bytes[0].drain) begin
                        if (frame_results_due.size() == 0) it = link_bytes.pop_front();
                    end else begin
                        it = link_bytes.pop_front();
                        v = 1'b1;
                        d = it.rx;
                    end
                end
            end
        end
        s_tvalid <= v;
        s_tdata <= d;
    end

    // Receiver: random stalls per result, plus two long hold-offs
    always @(negedge clk) begin
        logic rdy;
        rdy = 1'b0;
        if (rst_n) begin
            if (m_took) begin
                m_took = 1'b0;
                r_wait = draw_wait(r_quiet);
                if (results_checked == 60 || results_checked == 300) hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
                hold_left--;
            else if (r_wait > 0)
                r_wait--;
            else
                rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    initial begin
        int sel;
        int frames_built;
        int big_frames;
        int next_drain;
        logic [7:0] len;
        logic [7:0] fid;
        logic [7:0] fcnt;
        logic [7:0] junk;
        frame_flaw_e flaw;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        pstep = P_HUNT;
        cmd_r = '0;
        len_r = '0;
        seen_r = '0;
        xor_acc = '0;
        fid_r = '0;
        fcnt_r = '0;
        check_ok = 1'b0;
        wr_pos = '0;
        s_took = 1'b0;
        m_took = 1'b0;
        s_gap = 0;
        s_quiet = 0;
        r_wait = 0;
        r_quiet = 0;
        hold_left = 0;
        idle_cycles = 0;
        mismatches = 0;
        results_checked = 0;
        stim_bytes = 0;
        bytes_taken = 0;
        payload_results = 0;
        frames_more = 0;
        frames_done = 0;
        frames_rejected = 0;
        frames_built = 0;
        big_frames = 0;

        // Directed: doubled start byte, zero length, finished message
        push_byte(START_BYTE);
        add_frame(16'hFFFF, 8'd0, 8'h00, 8'h00, 8'h00, FLAW_NONE);
        // Bad direction byte drops back to hunting
        push_byte(START_BYTE);
        push_byte(8'h05);
        // Start byte as payload, more frames to follow
        add_frame(16'h0000, 8'd1, START_BYTE, 8'h01, 8'h02, FLAW_NONE);
        // Wrong tail rejects the frame
        add_frame(16'h8001, 8'd0, 8'h00, 8'hFF, 8'hFE, FLAW_TAIL);
        push_drain();

        // Random: mostly well-formed frames, some noise and broken framing
        next_drain = stim_bytes + DRAIN_EVERY;
        while (stim_bytes < RANDOM_BYTES + 31) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                if (sel >= 72) push_byte(START_BYTE);
                frames_built++;
                if (frames_built % 45 == 30) begin
                    len = (big_frames == 0) ? 8'd255 : 8'($urandom_range(200, 254));
                    big_frames++;
                end else begin
                    len = 8'($urandom_range(0, 12));
                end
                fcnt = 8'($urandom);
                fid = ($urandom_range(0, 99) < 30) ? fcnt : 8'($urandom);
                sel = $urandom_range(0, 99);
                flaw = (sel < 76) ? FLAW_NONE : (sel < 84) ? FLAW_CHECK :
                       (sel < 92) ? FLAW_TAIL : FLAW_CUT;
                add_frame(16'($urandom), len, 8'($urandom), fid, fcnt, flaw);
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            end else begin
                junk = 8'($urandom);
                if (junk == DIR_BYTE) junk = 8'h02;
                push_byte(START_BYTE);
                push_byte(junk);
            end
            if (stim_bytes >= next_drain) begin
                push_drain();
                next_drain += DRAIN_EVERY;
            end
        end

        // Release reset on a falling clock edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Let the stimulus run out, then collect every outstanding result
        while (link_bytes.size() != 0 || s_tvalid) @(posedge clk);
        while (frame_results_due.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d bytes; checked %0d results: %0d payload bytes, %0d frame ends",
                 bytes_taken, results_checked, payload_results,
                 frames_more + frames_done + frames_rejected);
        $display("Frame ends: %0d more-to-follow, %0d finished, %0d rejected",
                 frames_more, frames_done, frames_rejected);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
